// ===== rtl/psd_pkg.sv =====
// Package for the polyline segment direction block.
// Holds sizes, payload types and the controller/datapath command and status structs.
// No dependencies.
package psd_pkg;

   localparam int unsigned MAX_POINTS = 64;
   localparam int unsigned ADDR_W     = $clog2(MAX_POINTS);
   localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int unsigned COORD_W    = 32;
   localparam int unsigned DIR_W      = 17;
   localparam int unsigned IDX_W      = 6;
   localparam int unsigned NUM_AXES   = 3;
   localparam int unsigned MAG_W      = COORD_W + 1;
   localparam int unsigned NRM_W      = 31;
   localparam int unsigned PROD_W     = 2 * NRM_W;
   localparam int unsigned SUM_W      = 64;
   localparam int unsigned ROOT_W     = SUM_W / 2;
   localparam int unsigned QUO_W      = 17;
   localparam int unsigned NUM_W      = NRM_W + QUO_W;
   localparam int unsigned STEP_W     = 5;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIR_W-1:0]   dir_type;
   typedef logic [ADDR_W-1:0]         addr_type;

   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      logic     rd_en;
      addr_type rd_a;
      addr_type rd_b;
      logic     nz_clr;
      logic     nz_wr;
      addr_type nz_idx;
      logic     diff_load;
      logic     norm_step;
      logic     mul_en;
      logic [1:0] axis;
      logic     acc_en;
      logic     acc_clr;
      logic     sqrt_step;
      logic     div_init;
      logic     div_step;
      logic     div_last;
      logic     o_clr;
      logic     out_load;
      logic     out_zero;
      logic     out_collapsed;
      logic     out_last;
      addr_type out_idx;
   } psd_cmd_type;

   typedef struct packed {
      logic [MAX_POINTS-1:0] nz;
      logic zero_span;
      logic norm_done;
      logic out_free;
   } psd_stat_type;

endpackage

// ===== rtl/psd_if.sv =====
// Valid/ready channel interfaces for point requests and direction responses.
// Depends on psd_pkg.
interface psd_req_if;
   logic                valid;
   logic                ready;
   psd_pkg::coord_type  point_x;
   psd_pkg::coord_type  point_y;
   psd_pkg::coord_type  point_z;
   logic                last_point;

   modport source (output valid, point_x, point_y, point_z, last_point, input ready);
   modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface psd_rsp_if;
   logic                            valid;
   logic                            ready;
   psd_pkg::dir_type                dir_x;
   psd_pkg::dir_type                dir_y;
   psd_pkg::dir_type                dir_z;
   logic [psd_pkg::IDX_W-1:0]       segment_index;
   logic                            collapsed;
   logic                            last_result;

   modport source (output valid, dir_x, dir_y, dir_z, segment_index, collapsed, last_result,
                   input ready);
   modport sink   (input valid, dir_x, dir_y, dir_z, segment_index, collapsed, last_result,
                   output ready);
endinterface

// ===== rtl/polyline_segment_directions.sv =====
// Polyline segment directions: one point transfer per cycle while loading; after the last
// point, a scan of every segment and a check, then for each direction a normalizing shift,
// the squares, a square root, three divides on one shared unit and the output load. A
// borrowed span passes through a pick state, a zero-length span skips the arithmetic, and a
// neighbor search may run over a run of empty segments. Reset is synchronous and active
// high; the store needs no clearing pass; the next point waits for the last direction.
module polyline_segment_directions (
   input  logic    clock,
   input  logic    reset,
   psd_req_if.sink   req_if,
   psd_rsp_if.source rsp_if
);
   import psd_pkg::*;

   // The controller owns all sequencing; the datapath only acts on its command struct
   // and reports the segment flags, the normalizer condition and response availability.
   psd_cmd_type  cmd;
   psd_stat_type stat;

   psd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last_point),
      .req_ready (req_if.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // The datapath holds the point store, the arithmetic units and the response
   // register, so a finished direction waits there while the next one is computed.
   psd_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .pt_x          (req_if.point_x),
      .pt_y          (req_if.point_y),
      .pt_z          (req_if.point_z),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_dir_x     (rsp_if.dir_x),
      .rsp_dir_y     (rsp_if.dir_y),
      .rsp_dir_z     (rsp_if.dir_z),
      .rsp_index     (rsp_if.segment_index),
      .rsp_collapsed (rsp_if.collapsed),
      .rsp_last      (rsp_if.last_result)
   );

`ifndef SYNTHESIS
   // A collapsed result is always the only one of its run.
   a_collapsed_last: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.collapsed |-> rsp_if.last_result)
      else $error("collapsed result without last flag");

   // A collapsed result carries no direction.
   a_collapsed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.collapsed |->
         rsp_if.dir_x == '0 && rsp_if.dir_y == '0 && rsp_if.dir_z == '0)
      else $error("collapsed result with nonzero direction");

   // Directions are unit vectors: no component beyond one in Q1.15.
   a_dir_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |->
         rsp_if.dir_x <= 17'sd32768 && rsp_if.dir_x >= -17'sd32768 &&
         rsp_if.dir_y <= 17'sd32768 && rsp_if.dir_y >= -17'sd32768 &&
         rsp_if.dir_z <= 17'sd32768 && rsp_if.dir_z >= -17'sd32768)
      else $error("direction component out of range");
`endif

endmodule

// ===== rtl/psd_dp.sv =====
// Datapath: point store, nonzero-segment flags, normalizer, square root and divider,
// and the response register. Depends on psd_pkg.
module psd_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  psd_pkg::psd_cmd_type      cmd,
   output psd_pkg::psd_stat_type     stat,
   input  psd_pkg::coord_type        pt_x,
   input  psd_pkg::coord_type        pt_y,
   input  psd_pkg::coord_type        pt_z,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output psd_pkg::dir_type          rsp_dir_x,
   output psd_pkg::dir_type          rsp_dir_y,
   output psd_pkg::dir_type          rsp_dir_z,
   output logic [psd_pkg::IDX_W-1:0] rsp_index,
   output logic                      rsp_collapsed,
   output logic                      rsp_last
);
   import psd_pkg::*;

   logic [NUM_AXES*COORD_W-1:0] point_mem_ff [MAX_POINTS];
   logic [NUM_AXES*COORD_W-1:0] rd_a_ff, rd_b_ff;
   logic [MAX_POINTS-1:0]       nz_ff;
   logic [MAG_W-1:0]            mag_ff [NUM_AXES];
   logic [MAG_W-1:0]            mag_in [NUM_AXES];
   logic [NUM_AXES-1:0]         neg_ff, neg_in;
   logic [MAG_W-1:0]            mx_ff, mx_in;
   logic [PROD_W-1:0]           prod_ff;
   logic [SUM_W-1:0]            sum_ff;
   logic [MAG_W-1:0]            rem_ff;
   logic [ROOT_W-1:0]           root_ff;
   logic [MAG_W-1:0]            dvsr_ff;
   logic [MAG_W-1:0]            drem_ff;
   logic [QUO_W-1:0]            nlo_ff;
   logic [QUO_W-1:0]            quo_ff;
   logic                        dsign_ff;
   logic [1:0]                  daxis_ff;
   dir_type                     o_ff [NUM_AXES];
   logic                        valid_ff;
   dir_type                     dx_ff, dy_ff, dz_ff;
   logic [IDX_W-1:0]            idx_ff;
   logic                        coll_ff, last_ff;

   logic [NRM_W-1:0]            mul_op;
   logic [NRM_W-1:0]            div_m;
   logic                        div_neg;
   logic [NUM_W-1:0]            num;
   logic [MAG_W+2:0]            sq_rem_n;
   logic [MAG_W+2:0]            sq_trial;
   logic                        sq_ge;
   logic [MAG_W:0]              dv_rem_n;
   logic                        dv_ge;
   logic [QUO_W-1:0]            q_next;

   // Store and read ports; the read data is registered.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         point_mem_ff[cmd.wr_addr] <= {pt_x, pt_y, pt_z};
      end
      if (cmd.rd_en) begin
         rd_a_ff <= point_mem_ff[cmd.rd_a];
         rd_b_ff <= point_mem_ff[cmd.rd_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nz_ff <= '0;
      end else if (cmd.nz_clr) begin
         nz_ff <= '0;
      end else if (cmd.nz_wr) begin
         nz_ff[cmd.nz_idx] <= (rd_a_ff != rd_b_ff);
      end
   end

   // Span difference, magnitudes and the shared normalizing shift.
   always_comb begin
      mx_in = '0;
      for (int k = 0; k < NUM_AXES; k++) begin
         logic signed [MAG_W-1:0] d;
         logic signed [MAG_W-1:0] av;
         logic signed [MAG_W-1:0] bv;
         av = MAG_W'(signed'(rd_a_ff[(NUM_AXES-1-k)*COORD_W +: COORD_W]));
         bv = MAG_W'(signed'(rd_b_ff[(NUM_AXES-1-k)*COORD_W +: COORD_W]));
         d = bv - av;
         neg_in[k] = d[MAG_W-1];
         mag_in[k] = d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
         if (mag_in[k] > mx_in) begin
            mx_in = mag_in[k];
         end
      end
   end

   always_comb begin
      case (cmd.axis)
         2'd1:    mul_op = mag_ff[1][NRM_W-1:0];
         2'd2:    mul_op = mag_ff[2][NRM_W-1:0];
         default: mul_op = mag_ff[0][NRM_W-1:0];
      endcase
      case (cmd.axis)
         2'd1:    begin div_m = mag_ff[1][NRM_W-1:0]; div_neg = neg_ff[1]; end
         2'd2:    begin div_m = mag_ff[2][NRM_W-1:0]; div_neg = neg_ff[2]; end
         default: begin div_m = mag_ff[0][NRM_W-1:0]; div_neg = neg_ff[0]; end
      endcase
      num      = NUM_W'({div_m, (QUO_W-1)'(0)}) + NUM_W'(root_ff);
      sq_rem_n = {rem_ff, sum_ff[SUM_W-1 -: 2]};
      sq_trial = (MAG_W+3)'({root_ff, 2'b01});
      sq_ge    = (sq_rem_n >= sq_trial);
      dv_rem_n = {drem_ff, nlo_ff[QUO_W-1]};
      dv_ge    = (dv_rem_n >= (MAG_W+1)'(dvsr_ff));
      q_next   = {quo_ff[QUO_W-2:0], dv_ge};
   end

   always_ff @(posedge clock) begin
      if (cmd.diff_load) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            mag_ff[k] <= mag_in[k];
         end
         neg_ff <= neg_in;
         mx_ff  <= mx_in;
      end else if (cmd.norm_step) begin
         if (mx_ff[MAG_W-1:NRM_W] != '0) begin
            for (int k = 0; k < NUM_AXES; k++) begin
               mag_ff[k] <= mag_ff[k] >> 1;
            end
            mx_ff <= mx_ff >> 1;
         end else begin
            for (int k = 0; k < NUM_AXES; k++) begin
               mag_ff[k] <= mag_ff[k] << 1;
            end
            mx_ff <= mx_ff << 1;
         end
      end

      if (cmd.mul_en) begin
         prod_ff <= mul_op * mul_op;
      end

      // Sum of squares, then a digit-by-digit square root over the same register.
      if (cmd.acc_en) begin
         sum_ff <= cmd.acc_clr ? SUM_W'(prod_ff) : sum_ff + SUM_W'(prod_ff);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         sum_ff  <= sum_ff << 2;
         rem_ff  <= sq_ge ? MAG_W'(sq_rem_n - sq_trial) : MAG_W'(sq_rem_n);
         root_ff <= {root_ff[ROOT_W-2:0], sq_ge};
      end

      // Restoring divide of (m * 2^16 + s) by 2s, one quotient bit a cycle.
      if (cmd.div_init) begin
         dvsr_ff  <= {root_ff, 1'b0};
         drem_ff  <= MAG_W'(num[NUM_W-1:QUO_W]);
         nlo_ff   <= num[QUO_W-1:0];
         quo_ff   <= '0;
         dsign_ff <= div_neg;
         daxis_ff <= cmd.axis;
      end else if (cmd.div_step) begin
         drem_ff <= dv_ge ? MAG_W'(dv_rem_n - (MAG_W+1)'(dvsr_ff)) : MAG_W'(dv_rem_n);
         nlo_ff  <= nlo_ff << 1;
         quo_ff  <= q_next;
      end

      if (cmd.o_clr) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            o_ff[k] <= '0;
         end
      end else if (cmd.div_step && cmd.div_last) begin
         o_ff[daxis_ff] <= dsign_ff ? dir_type'(~q_next + 1'b1) : dir_type'(q_next);
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         dx_ff   <= cmd.out_zero ? '0 : o_ff[0];
         dy_ff   <= cmd.out_zero ? '0 : o_ff[1];
         dz_ff   <= cmd.out_zero ? '0 : o_ff[2];
         idx_ff  <= IDX_W'(cmd.out_idx);
         coll_ff <= cmd.out_collapsed;
         last_ff <= cmd.out_last;
      end
   end

   assign stat.nz        = nz_ff;
   assign stat.zero_span = (mx_ff == '0);
   assign stat.norm_done = (mx_ff[MAG_W-1:NRM_W-1] == 3'b001);
   assign stat.out_free  = !valid_ff || rsp_ready;

   assign rsp_valid     = valid_ff;
   assign rsp_dir_x     = dx_ff;
   assign rsp_dir_y     = dy_ff;
   assign rsp_dir_z     = dz_ff;
   assign rsp_index     = idx_ff;
   assign rsp_collapsed = coll_ff;
   assign rsp_last      = last_ff;

endmodule

// ===== rtl/psd_ctrl.sv =====
// Controller: point counting, segment scan, neighbor search and arithmetic sequencing.
// Depends on psd_pkg; drives psd_dp through the command struct.
module psd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   output logic                  req_ready,
   output psd_pkg::psd_cmd_type  cmd,
   input  psd_pkg::psd_stat_type stat
);
   import psd_pkg::*;

   typedef enum logic [3:0] {
      ST_LOAD, ST_SCAN_RD, ST_SCAN_CMP, ST_CHECK, ST_COLLAPSE, ST_DECIDE, ST_SEARCH,
      ST_PICK, ST_READ, ST_DIFF, ST_NORM, ST_MUL, ST_SQRT, ST_DIV_INIT, ST_DIV, ST_OUT
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   addr_type         segs_ff, segs_in;
   addr_type         i_ff, i_in;
   addr_type         r_ff, r_in;
   addr_type         l_ff, l_in;
   logic             lv_ff, lv_in;
   addr_type         a_ff, a_in;
   addr_type         b_ff, b_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [1:0]       axis_ff, axis_in;

   logic             accept;
   logic [CNT_W-1:0] cnt_plus;
   logic             right;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         segs_ff  <= '0;
         i_ff     <= '0;
         r_ff     <= '0;
         l_ff     <= '0;
         lv_ff    <= 1'b0;
         a_ff     <= '0;
         b_ff     <= '0;
         step_ff  <= '0;
         axis_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         segs_ff  <= segs_in;
         i_ff     <= i_in;
         r_ff     <= r_in;
         l_ff     <= l_in;
         lv_ff    <= lv_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         step_ff  <= step_in;
         axis_ff  <= axis_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      segs_in  = segs_ff;
      i_in     = i_ff;
      r_in     = r_ff;
      l_in     = l_ff;
      lv_in    = lv_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      step_in  = step_ff;
      axis_in  = axis_ff;
      cmd      = '0;
      req_ready = (state_ff == ST_LOAD);
      accept   = req_valid && req_ready;
      cnt_plus = count_ff;
      right    = (r_ff != segs_ff);

      cmd.rd_a    = i_ff;
      cmd.rd_b    = i_ff + 1'b1;
      cmd.nz_idx  = i_ff;
      cmd.out_idx = i_ff;
      cmd.axis    = axis_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               cmd.wr_en   = (count_ff < CNT_W'(MAX_POINTS));
               cmd.wr_addr = count_ff[ADDR_W-1:0];
               cnt_plus    = cmd.wr_en ? count_ff + 1'b1 : count_ff;
               count_in    = cnt_plus;
               if (req_last) begin
                  cmd.nz_clr = 1'b1;
                  count_in   = '0;
                  segs_in    = ADDR_W'(cnt_plus - 1'b1);
                  i_in       = '0;
                  r_in       = '0;
                  lv_in      = 1'b0;
                  state_in   = (cnt_plus == CNT_W'(1)) ? ST_CHECK : ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            cmd.nz_wr = 1'b1;
            if (i_ff == segs_ff - 1'b1) begin
               i_in     = '0;
               state_in = ST_CHECK;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_CHECK: begin
            state_in = (stat.nz != '0) ? ST_DECIDE : ST_COLLAPSE;
         end
         ST_COLLAPSE: begin
            if (stat.out_free) begin
               cmd.out_load      = 1'b1;
               cmd.out_zero      = 1'b1;
               cmd.out_collapsed = 1'b1;
               cmd.out_last      = 1'b1;
               cmd.out_idx       = '0;
               state_in          = ST_LOAD;
            end
         end
         ST_DECIDE: begin
            if (stat.nz[i_ff]) begin
               a_in     = i_ff;
               b_in     = i_ff + 1'b1;
               l_in     = i_ff;
               lv_in    = 1'b1;
               state_in = ST_READ;
            end else if (r_ff <= i_ff) begin
               r_in     = i_ff + 1'b1;
               state_in = ST_SEARCH;
            end else begin
               state_in = ST_PICK;
            end
         end
         ST_SEARCH: begin
            if ((r_ff == segs_ff) || stat.nz[r_ff]) begin
               state_in = ST_PICK;
            end else begin
               r_in = r_ff + 1'b1;
            end
         end
         ST_PICK: begin
            if (right && (r_ff == i_ff + 1'b1)) begin
               a_in = i_ff;
               b_in = r_ff + 1'b1;
            end else begin
               a_in = lv_ff ? l_ff : '0;
               b_in = right ? r_ff + 1'b1 : segs_ff;
            end
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            cmd.rd_a  = a_ff;
            cmd.rd_b  = b_ff;
            state_in  = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff_load = 1'b1;
            state_in      = ST_NORM;
         end
         ST_NORM: begin
            if (stat.zero_span) begin
               cmd.o_clr = 1'b1;
               state_in  = ST_OUT;
            end else if (stat.norm_done) begin
               step_in  = '0;
               state_in = ST_MUL;
            end else begin
               cmd.norm_step = 1'b1;
            end
         end
         ST_MUL: begin
            cmd.axis    = step_ff[1:0];
            cmd.mul_en  = (step_ff[1:0] != 2'd3);
            cmd.acc_en  = (step_ff[1:0] != 2'd0);
            cmd.acc_clr = (step_ff[1:0] == 2'd1);
            if (step_ff[1:0] == 2'd3) begin
               step_in  = '0;
               state_in = ST_SQRT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == '1) begin
               axis_in  = '0;
               state_in = ST_DIV_INIT;
            end
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            step_in      = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.div_last = (step_ff == STEP_W'(QUO_W - 1));
            step_in      = step_ff + 1'b1;
            if (cmd.div_last) begin
               axis_in  = axis_ff + 1'b1;
               state_in = (axis_ff == 2'(NUM_AXES - 1)) ? ST_OUT : ST_DIV_INIT;
            end
         end
         ST_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = (i_ff == segs_ff - 1'b1);
               if (cmd.out_last) begin
                  state_in = ST_LOAD;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_DECIDE;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

endmodule
